// ----- sv/gbn_pkg.sv -----
// Package for the go-back-N sender window: field widths, mode and result
// codes, and the result word that passes from the sequencer to the output stage.
// Used by gbn_ctrl, gbn_out and go_back_n_sender_window; it depends on nothing.
package gbn_pkg;

  localparam int MODE_W    = 2;
  localparam int KIND_W    = 3;
  localparam int SEQ_OUT_W = 3;
  localparam int DUR_W     = 16;

  localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PACKET  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STOP    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd4;

  localparam logic [DUR_W-1:0] HOLD_TICKS  = 16'd6;
  localparam logic [DUR_W-1:0] TIMEOUT_RST = 16'd20;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [SEQ_OUT_W-1:0] seq;
    logic [DUR_W-1:0]     duration;
    logic                 window_full;
    logic                 last;
  } res_t;

endpackage

// ----- sv/go_back_n_sender_window.sv -----
// Go-back-N sender window, top level: window RAM, sequencer and output stage.
// Depends on gbn_pkg, gbn_ram, gbn_ctrl and gbn_out.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-----------------------
//   input   | in_mode/payload/ack_num/ack_checksum_ok | in_valid / in_ready
//           | /timer_id                               |
//   result  | out_kind/seq/packet_data/duration/      | out_valid / out_ready
//           | window_full/last                        |
//   config  | cfg_wr_data (timeout_ticks)             | cfg_wr_en, no wait
//
// One word at a time, in_ready only while idle; each entry visited costs one RAM read.
// A low out_ready holds the sequencer. Send gives a packet, or a refusal on a full
// window, and a timer start when the window was empty; timeout stops the timer,
// resends every window entry and starts the timer; ack is ignored on a bad checksum
// or with no match, else stops each acked entry, then restarts the timer if entries remain.
// Reset (rst_n low, synchronous) empties the window and sets timeout_ticks to 20.
module go_back_n_sender_window #(
  parameter int WINDOW_SIZE  = 4,
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [gbn_pkg::DUR_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gbn_pkg::MODE_W-1:0]    in_mode,
  input  logic [PAYLOAD_BITS-1:0]       in_payload,
  input  logic [gbn_pkg::SEQ_OUT_W-1:0] in_ack_num,
  input  logic                          in_ack_checksum_ok,
  input  logic [gbn_pkg::SEQ_OUT_W-1:0] in_timer_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gbn_pkg::KIND_W-1:0]    out_kind,
  output logic [gbn_pkg::SEQ_OUT_W-1:0] out_seq,
  output logic [PAYLOAD_BITS-1:0]       out_packet_data,
  output logic [gbn_pkg::DUR_W-1:0]     out_duration,
  output logic                          out_window_full,
  output logic                          out_last
);

  localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int SEQ_W = $clog2(SEQ_SPACE);
  localparam int RAM_W = PAYLOAD_BITS + SEQ_W;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [RAM_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [RAM_W-1:0]        ram_rdata;
  logic                    emit_vld;
  logic                    emit_ok;
  gbn_pkg::res_t           emit_res;
  logic [PAYLOAD_BITS-1:0] emit_data;
  gbn_pkg::res_t           out_res;

  gbn_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WINDOW_SIZE)
  ) u_win_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gbn_ctrl #(
    .WINDOW_SIZE  (WINDOW_SIZE),
    .SEQ_SPACE    (SEQ_SPACE),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_payload         (in_payload),
    .in_ack_num         (in_ack_num),
    .in_ack_checksum_ok (in_ack_checksum_ok),
    .in_timer_id        (in_timer_id),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .emit_vld           (emit_vld),
    .emit_res           (emit_res),
    .emit_data          (emit_data),
    .emit_ok            (emit_ok)
  );

  gbn_out #(
    .DATA_W (PAYLOAD_BITS)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit_vld  (emit_vld),
    .emit_res  (emit_res),
    .emit_data (emit_data),
    .emit_ok   (emit_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .out_data  (out_packet_data)
  );

  assign out_kind        = out_res.kind;
  assign out_seq         = out_res.seq;
  assign out_duration    = out_res.duration;
  assign out_window_full = out_res.window_full;
  assign out_last        = out_res.last;

endmodule

// ----- sv/gbn_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the window entries; no dependencies.
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/gbn_out.sv -----
// Output register for result words: holds one word until the consumer takes it.
// Depends on gbn_pkg for the result word type.
module gbn_out #(
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              emit_vld,
  input  gbn_pkg::res_t     emit_res,
  input  logic [DATA_W-1:0] emit_data,
  output logic              emit_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output gbn_pkg::res_t     out_res,
  output logic [DATA_W-1:0] out_data
);

  logic              vld_r;
  logic              vld_nxt;
  gbn_pkg::res_t     res_r;
  logic [DATA_W-1:0] data_r;

  // a new word may load when the slot is empty or drains this cycle
  assign emit_ok = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (emit_ok) begin
      vld_nxt = emit_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok && emit_vld) begin
      res_r  <= emit_res;
      data_r <= emit_data;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;
  assign out_data  = data_r;

endmodule

// ----- sv/gbn_ctrl.sv -----
// Sequencer of the sender window: window bookkeeping, sequence compares
// walked over the window RAM, and result word generation.
// Depends on gbn_pkg; drives the window RAM and the output stage.
module gbn_ctrl #(
  parameter int WINDOW_SIZE  = 4,
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 64,
  localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1,
  localparam int SEQ_W = $clog2(SEQ_SPACE),
  localparam int RAM_W = PAYLOAD_BITS + SEQ_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [gbn_pkg::DUR_W-1:0]       cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gbn_pkg::MODE_W-1:0]      in_mode,
  input  logic [PAYLOAD_BITS-1:0]         in_payload,
  input  logic [gbn_pkg::SEQ_OUT_W-1:0]   in_ack_num,
  input  logic                            in_ack_checksum_ok,
  input  logic [gbn_pkg::SEQ_OUT_W-1:0]   in_timer_id,
  output logic                            ram_we,
  output logic [IDX_W-1:0]                ram_waddr,
  output logic [RAM_W-1:0]                ram_wdata,
  output logic [IDX_W-1:0]                ram_raddr,
  input  logic [RAM_W-1:0]                ram_rdata,
  output logic                            emit_vld,
  output gbn_pkg::res_t                   emit_res,
  output logic [PAYLOAD_BITS-1:0]         emit_data,
  input  logic                            emit_ok
);

  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
  localparam int CMP_W = (SEQ_W > gbn_pkg::SEQ_OUT_W) ? SEQ_W : gbn_pkg::SEQ_OUT_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEND   = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_IGN    = 4'd3;
  localparam logic [3:0] S_SRCH   = 4'd4;
  localparam logic [3:0] S_STOP   = 4'd5;
  localparam logic [3:0] S_HELD   = 4'd6;
  localparam logic [3:0] S_TSTOP  = 4'd7;
  localparam logic [3:0] S_RESEND = 4'd8;

  function automatic logic [IDX_W-1:0] slot_adv(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(WINDOW_SIZE - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    return (s == SEQ_W'(SEQ_SPACE - 1)) ? '0 : s + 1'b1;
  endfunction

  logic [3:0]                          state_r, state_nxt;
  logic [IDX_W-1:0]                    head_r, head_nxt;
  logic [IDX_W-1:0]                    tail_r, tail_nxt;
  logic [CNT_W-1:0]                    count_r, count_nxt;
  logic [SEQ_W-1:0]                    next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]                    base_seq_r, base_seq_nxt;
  logic                                full_r, full_nxt;
  logic [gbn_pkg::DUR_W-1:0]           timeout_r;
  logic [IDX_W-1:0]                    ptr_r, ptr_nxt;
  logic [CNT_W-1:0]                    idx_r, idx_nxt;

  logic [gbn_pkg::MODE_W-1:0]          mode_r, mode_nxt;
  logic [PAYLOAD_BITS-1:0]             payload_r, payload_nxt;
  logic [gbn_pkg::SEQ_OUT_W-1:0]       ack_r, ack_nxt;
  logic [gbn_pkg::SEQ_OUT_W-1:0]       tid_r, tid_nxt;
  logic [CNT_W-1:0]                    found_r, found_nxt;
  logic [gbn_pkg::DUR_W-1:0]           hold_r, hold_nxt;
  logic [gbn_pkg::DUR_W-1:0]           dur_r, dur_nxt;

  logic [SEQ_W-1:0]                    rd_seq;
  logic [PAYLOAD_BITS-1:0]             rd_payload;
  logic [CNT_W-1:0]                    idx_inc;

  assign rd_seq     = ram_rdata[SEQ_W-1:0];
  assign rd_payload = ram_rdata[RAM_W-1:SEQ_W];
  assign idx_inc    = idx_r + 1'b1;
  assign in_ready   = (state_r == S_IDLE);

  // read address follows ptr_nxt, so ram_rdata always holds the entry at ptr_r
  assign ram_raddr = ptr_nxt;
  assign ram_waddr = tail_r;
  assign ram_wdata = {payload_r, next_seq_r};

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    next_seq_nxt = next_seq_r;
    base_seq_nxt = base_seq_r;
    full_nxt     = full_r;
    ptr_nxt      = ptr_r;
    idx_nxt      = idx_r;
    mode_nxt     = mode_r;
    payload_nxt  = payload_r;
    ack_nxt      = ack_r;
    tid_nxt      = tid_r;
    found_nxt    = found_r;
    hold_nxt     = hold_r;
    dur_nxt      = dur_r;
    ram_we       = 1'b0;
    emit_vld     = 1'b0;
    emit_res     = '0;
    emit_data    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt    = in_mode;
          payload_nxt = in_payload;
          ack_nxt     = in_ack_num;
          tid_nxt     = in_timer_id;
          ptr_nxt     = head_r;
          idx_nxt     = '0;
          hold_nxt    = '0;
          case (in_mode)
            gbn_pkg::MODE_SEND:    state_nxt = S_SEND;
            gbn_pkg::MODE_ACK:     state_nxt = in_ack_checksum_ok ? S_SRCH : S_IGN;
            gbn_pkg::MODE_TIMEOUT: state_nxt = S_TSTOP;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end

      S_SEND: begin
        if (emit_ok) begin
          emit_vld = 1'b1;
          if (full_r) begin
            emit_res.kind        = gbn_pkg::KIND_REFUSED;
            emit_res.window_full = 1'b1;
            emit_res.last        = 1'b1;
            state_nxt            = S_IDLE;
          end else begin
            emit_res.kind        = gbn_pkg::KIND_PACKET;
            emit_res.seq         = gbn_pkg::SEQ_OUT_W'(next_seq_r);
            emit_res.window_full = (idx_inc == '0) ? 1'b0 :
                                   ((count_r + 1'b1) == CNT_W'(WINDOW_SIZE));
            emit_res.last        = (count_r != '0);
            emit_data            = payload_r;
            ram_we               = 1'b1;
            count_nxt            = count_r + 1'b1;
            tail_nxt             = slot_adv(tail_r);
            next_seq_nxt         = seq_inc(next_seq_r);
            full_nxt             = ((count_r + 1'b1) == CNT_W'(WINDOW_SIZE));
            dur_nxt              = timeout_r;
            state_nxt            = (count_r == '0) ? S_START : S_IDLE;
          end
        end
      end

      S_START: begin
        if (emit_ok) begin
          emit_vld             = 1'b1;
          emit_res.kind        = gbn_pkg::KIND_START;
          emit_res.seq         = (mode_r == gbn_pkg::MODE_TIMEOUT) ? tid_r :
                                 gbn_pkg::SEQ_OUT_W'(base_seq_r);
          emit_res.duration    = dur_r;
          emit_res.window_full = full_r;
          emit_res.last        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end

      S_IGN: begin
        if (emit_ok) begin
          emit_vld             = 1'b1;
          emit_res.kind        = gbn_pkg::KIND_IGNORED;
          emit_res.seq         = ack_r;
          emit_res.window_full = full_r;
          emit_res.last        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end

      // walk the window for the oldest entry that carries the acked number
      S_SRCH: begin
        if (idx_r == count_r) begin
          state_nxt = S_IGN;
        end else if (CMP_W'(rd_seq) == CMP_W'(ack_r)) begin
          found_nxt    = idx_inc;
          base_seq_nxt = seq_inc(rd_seq);
          ptr_nxt      = head_r;
          idx_nxt      = '0;
          state_nxt    = S_STOP;
        end else begin
          idx_nxt = idx_inc;
          ptr_nxt = slot_adv(ptr_r);
        end
      end

      // stop timers of the acked entries, then drop them
      S_STOP: begin
        if (emit_ok) begin
          emit_vld          = 1'b1;
          emit_res.kind     = gbn_pkg::KIND_STOP;
          emit_res.seq      = gbn_pkg::SEQ_OUT_W'(rd_seq);
          emit_res.last     = (idx_inc == found_r) && (count_r == found_r);
          hold_nxt          = hold_r + gbn_pkg::HOLD_TICKS;
          idx_nxt           = idx_inc;
          ptr_nxt           = slot_adv(ptr_r);
          if (idx_inc == found_r) begin
            head_nxt  = slot_adv(ptr_r);
            count_nxt = count_r - found_r;
            full_nxt  = 1'b0;
            idx_nxt   = '0;
            state_nxt = (count_r != found_r) ? S_HELD : S_IDLE;
          end
        end
      end

      // look for base among the remaining entries to pick the restart duration
      S_HELD: begin
        if (idx_r == count_r) begin
          dur_nxt   = timeout_r;
          state_nxt = S_START;
        end else if (rd_seq == base_seq_r) begin
          dur_nxt   = hold_r;
          state_nxt = S_START;
        end else begin
          idx_nxt = idx_inc;
          ptr_nxt = slot_adv(ptr_r);
        end
      end

      S_TSTOP: begin
        if (emit_ok) begin
          emit_vld             = 1'b1;
          emit_res.kind        = gbn_pkg::KIND_STOP;
          emit_res.seq         = tid_r;
          emit_res.window_full = full_r;
          state_nxt            = S_RESEND;
        end
      end

      S_RESEND: begin
        if (idx_r == count_r) begin
          dur_nxt   = timeout_r;
          state_nxt = S_START;
        end else if (emit_ok) begin
          emit_vld             = 1'b1;
          emit_res.kind        = gbn_pkg::KIND_PACKET;
          emit_res.seq         = gbn_pkg::SEQ_OUT_W'(rd_seq);
          emit_res.window_full = full_r;
          emit_data            = rd_payload;
          idx_nxt              = idx_inc;
          ptr_nxt              = slot_adv(ptr_r);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      next_seq_r <= '0;
      base_seq_r <= '0;
      full_r     <= 1'b0;
      ptr_r      <= '0;
      idx_r      <= '0;
      timeout_r  <= gbn_pkg::TIMEOUT_RST;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      next_seq_r <= next_seq_nxt;
      base_seq_r <= base_seq_nxt;
      full_r     <= full_nxt;
      ptr_r      <= ptr_nxt;
      idx_r      <= idx_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    payload_r <= payload_nxt;
    ack_r     <= ack_nxt;
    tid_r     <= tid_nxt;
    found_r   <= found_nxt;
    hold_r    <= hold_nxt;
    dur_r     <= dur_nxt;
  end

endmodule
